// File: hdl/rpn_evaluation_stack_defines.svh
// ---------------------------------------------------------------------------
// rpn_evaluation_stack_defines
// Assertion macros shared by the evaluation stack RTL.
// ---------------------------------------------------------------------------
`ifndef RPN_EVALUATION_STACK_DEFINES_SVH
`define RPN_EVALUATION_STACK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RPNES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RPNES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rpnes_pkg.sv
// ---------------------------------------------------------------------------
// rpnes_pkg
// Request and status codes plus the shift control word for the cell chain.
// ---------------------------------------------------------------------------
package rpnes_pkg;

  localparam int DataW = 32;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FEW       = 3'd1,
    ST_INVALID   = 3'd2,
    ST_POP_EMPTY = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // push: every cell takes its upper neighbor; pull: every cell takes its lower one
  typedef struct packed {
    logic push;
    logic pull;
  } shift_ctl_t;

endpackage

// File: hdl/rpnes_cell.sv
// ---------------------------------------------------------------------------
// rpnes_cell
// One stack entry; moves one place up or down the chain on command.
// ---------------------------------------------------------------------------
module rpnes_cell
  import rpnes_pkg::*;
(
  input  logic                    clk,
  input  shift_ctl_t              ctl,
  input  logic signed [DataW-1:0] above,
  input  logic signed [DataW-1:0] below,
  output logic signed [DataW-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= above;
    end else if (ctl.pull) begin
      q <= below;
    end
  end

endmodule

// File: hdl/rpnes_alu.sv
// ---------------------------------------------------------------------------
// rpnes_alu
// Saturating Q16.16 add and multiply of the top two entries.
// Product is registered on load; shift and clamp follow in the next cycle.
// ---------------------------------------------------------------------------
module rpnes_alu
  import rpnes_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic                    sel_mul,
  input  logic signed [DataW-1:0] a,
  input  logic signed [DataW-1:0] b,
  output logic signed [DataW-1:0] r
);

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  logic signed [2*DataW-1:0] prod;
  logic signed [2*DataW-1:0] prod_sh;
  logic signed [DataW:0]     sum;
  logic signed [DataW-1:0]   sum_sat;
  logic signed [DataW-1:0]   mul_sat;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= a * b;
    end
  end

  always_comb begin
    sum = {a[DataW-1], a} + {b[DataW-1], b};
    if (sum[DataW] != sum[DataW-1]) begin
      sum_sat = sum[DataW] ? SatMin : SatMax;
    end else begin
      sum_sat = sum[DataW-1:0];
    end

    // arithmetic shift is floor division by 2^16
    prod_sh = prod >>> 16;
    if (prod_sh[2*DataW-1] && !(&prod_sh[2*DataW-1:DataW-1])) begin
      mul_sat = SatMin;
    end else if (!prod_sh[2*DataW-1] && (|prod_sh[2*DataW-1:DataW-1])) begin
      mul_sat = SatMax;
    end else begin
      mul_sat = prod_sh[DataW-1:0];
    end

    r = sel_mul ? mul_sat : sum_sat;
  end

endmodule

// File: hdl/rpn_evaluation_stack.sv
// ---------------------------------------------------------------------------
// rpn_evaluation_stack
// Postfix calculator stack: push, pop, saturating Q16.16 add and multiply.
// ---------------------------------------------------------------------------
// A request accepted in idle moves the FSM to the exec state, which
// registers the done beat; busy is high during exec.
// No new request is taken while busy, so requests do not overlap; the
// registered 32x32 product is loaded at accept and used in exec.
// Reset (rst, synchronous): entry count cleared, FSM idle, no done beat.
// The receiver cannot stall: done is a one-cycle strobe.
// ---------------------------------------------------------------------------
module rpn_evaluation_stack
  import rpnes_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              req_type,
  input  logic signed [DataW-1:0] value,
  output logic                    done,
  output logic [2:0]              status,
  output logic signed [DataW-1:0] top_value,
  output logic                    is_empty
);

`include "rpn_evaluation_stack_defines.svh"

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state;
  logic [CntW-1:0]         count;
  logic [2:0]              op_r;
  logic signed [DataW-1:0] value_r;

  logic                    accept;
  logic                    is_arith;
  logic                    cnt_zero;
  logic                    cnt_one;
  logic                    cnt_full;
  logic signed [DataW-1:0] alu_r;
  logic signed [DataW-1:0] top0_below;
  logic signed [DataW-1:0] top_next;
  logic [CntW-1:0]         count_next;
  status_t                 status_next;
  shift_ctl_t              ctl;

  // Cell 0 is the top of stack; higher indices are deeper entries.
  logic signed [DataW-1:0] cell_q [STACK_DEPTH];

  assign accept   = start && !busy;
  assign busy     = (state == S_EXEC);
  assign is_arith = (op_r == OP_ADD) || (op_r == OP_MUL);
  assign cnt_zero = (count == '0);
  assign cnt_one  = (count == CntW'(1));
  assign cnt_full = (count == CntW'(STACK_DEPTH));

  // Product of the top two is taken at accept, while the chain is at rest.
  rpnes_alu u_alu (
    .clk    (clk),
    .load   (accept),
    .sel_mul(op_r == OP_MUL),
    .a      (cell_q[0]),
    .b      (cell_q[1]),
    .r      (alu_r)
  );

  // Decode of the held request during the exec cycle.
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = ST_OK;
    top_next    = cell_q[0];
    case (op_r)
      OP_PUSH: begin
        if (cnt_full) begin
          status_next = ST_FULL;      // value dropped
        end else begin
          ctl.push   = 1'b1;
          count_next = count + CntW'(1);
          top_next   = value_r;
        end
      end
      OP_POP: begin
        if (cnt_zero) begin
          status_next = ST_POP_EMPTY;
        end else begin
          ctl.pull   = 1'b1;
          count_next = count - CntW'(1);
          top_next   = cell_q[1];
        end
      end
      OP_ADD, OP_MUL: begin
        if (cnt_zero || cnt_one) begin
          status_next = ST_FEW;
        end else begin
          // top two fold into one: cell 0 takes the result, rest move up
          ctl.pull   = 1'b1;
          count_next = count - CntW'(1);
          top_next   = alu_r;
        end
      end
      default: begin
        // operand check wins over the bad opcode
        status_next = cnt_zero ? ST_FEW : ST_INVALID;
      end
    endcase
    if (!busy) begin
      ctl = '0;
    end
  end

  assign top0_below = is_arith ? alu_r : cell_q[1];

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic signed [DataW-1:0] above_d;
      logic signed [DataW-1:0] below_d;
      if (gi == 0) begin : g_top
        assign above_d = value_r;
        assign below_d = top0_below;
      end else if (gi == STACK_DEPTH - 1) begin : g_bottom
        assign above_d = cell_q[gi-1];
        assign below_d = '0;
      end else begin : g_mid
        assign above_d = cell_q[gi-1];
        assign below_d = cell_q[gi+1];
      end
      rpnes_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .above(above_d),
        .below(below_d),
        .q    (cell_q[gi])
      );
    end
  endgenerate

  // FSM, entry count and the registered result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= req_type;
            value_r <= value;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          count     <= count_next;
          status    <= status_next;
          is_empty  <= (count_next == '0);
          top_value <= (count_next == '0) ? '0 : top_next;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RPNES_ASSERT_NXT(a_accept_busy, accept, busy && !done, "accept must lead to a busy cycle")
  `RPNES_ASSERT_NXT(a_busy_done, busy, done && !busy, "exec cycle must end in a done beat")
  `RPNES_ASSERT_IMP(a_empty_count, done, is_empty == (count == '0), "empty flag off count")
  `RPNES_ASSERT_IMP(a_empty_zero, done && is_empty, top_value == '0, "empty stack nonzero top")
  `RPNES_ASSERT_IMP(a_count_bound, 1'b1, count <= CntW'(STACK_DEPTH), "count past depth")

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rpn_evaluation_stack
// Runs a directed table of requests that covers the stack extremes, every
// request code except 6, saturation in both directions and the full and empty cases.
// Then about 800 random requests go in, with the sender idling at 28%, then
// 52%, then not at all. Each done beat is compared against a behavioral
// copy of the stack kept in the bench or, for typed rows, the table answer.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rpnes_pkg::*;

  localparam int STACK_DEPTH = 16;
  // About 850 requests go in, plus idle gaps; this limit leaves a wide margin
  // over the slowest correct run.
  localparam int CYCLE_LIMIT = 60000;
  localparam int RANDOM_PER_PHASE = 266;

  // request codes with no package name: the invalid symbol and the spare codes
  localparam logic [2:0] OP_BAD   = 3'd4;
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hffff_0000;
  localparam logic [31:0] Q_ONE_5   = 32'h0001_8000;

  // what one done beat should carry
  typedef struct {
    status_t            st;
    logic signed [31:0] top;
    logic               empty;
  } calc_result_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    logic [2:0]  op;
    logic [31:0] val;
    int          reps;
    bit          typed;
    status_t     st;
    logic [31:0] top;
    bit          empty;
  } stim_row_t;

  localparam int NUM_ROWS = 27;

  // ---------------------------------------------------------------------------
  // DUT signals. All inputs start at known values.
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         req_type = OP_PUSH;
  logic signed [31:0] value = '0;
  logic               done;
  logic [2:0]         status;
  logic signed [31:0] top_value;
  logic               is_empty;

  rpn_evaluation_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .value    (value),
    .done     (done),
    .status   (status),
    .top_value(top_value),
    .is_empty (is_empty)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench copy of the stack. Only entries below calc_depth are ever read.
  // ---------------------------------------------------------------------------
  logic signed [31:0] calc_stack [STACK_DEPTH];
  int                 calc_depth = 0;
  int                 deepest = 0;

  calc_result_t awaited_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int requests_issued = 0;
  int status_tally [5] = '{0, 0, 0, 0, 0};
  int cycle_count = 0;

  // Applies one request to the bench stack and returns the beat it should give.
  // Operand check comes before the code check, so any non-push/pop code on an
  // empty stack reports too few operands.
  function automatic calc_result_t apply_request(logic [2:0] op, logic [31:0] val);
    calc_result_t r;
    longint       wide;
    r.st = ST_OK;
    if (op == OP_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        r.st = ST_FULL;              // value dropped
      end else begin
        calc_stack[calc_depth] = val;
        calc_depth++;
      end
    end else if (op == OP_POP) begin
      if (calc_depth == 0) r.st = ST_POP_EMPTY;
      else calc_depth--;
    end else if (calc_depth == 0) begin
      r.st = ST_FEW;
    end else if (op == OP_ADD || op == OP_MUL) begin
      if (calc_depth < 2) begin
        r.st = ST_FEW;               // one entry: stack left alone
      end else begin
        if (op == OP_ADD)
          wide = longint'(calc_stack[calc_depth-1]) + longint'(calc_stack[calc_depth-2]);
        else  // full 64-bit product, arithmetic shift floors toward minus infinity
          wide = (longint'(calc_stack[calc_depth-1]) *
                  longint'(calc_stack[calc_depth-2])) >>> 16;
        if (wide > longint'(32'sh7fff_ffff)) wide = longint'(32'sh7fff_ffff);
        if (wide < -longint'(64'sh8000_0000)) wide = -longint'(64'sh8000_0000);
        calc_depth--;
        calc_stack[calc_depth-1] = wide[31:0];
      end
    end else begin
      r.st = ST_INVALID;
    end
    r.empty = (calc_depth == 0);
    r.top   = r.empty ? '0 : calc_stack[calc_depth-1];
    return r;
  endfunction

  // Drive one request and hold it until the block takes it. start stays high
  // afterwards so that back-to-back requests need no extra assignment.
  task automatic issue_request(input logic [2:0] op, input logic [31:0] val,
                               output calc_result_t predicted);
    start    <= 1'b1;
    req_type <= op;
    value    <= val;
    do @(posedge clk); while (busy);
    predicted = apply_request(op, val);
    requests_issued++;
    if (calc_depth > deepest) deepest = calc_depth;
  endtask

  // Hold off the sender until every outstanding beat has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed answers are the ones that follow directly
  // from the definition; the rest are left to the bench stack.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [NUM_ROWS] = '{
    // non-push codes on an empty stack: pop, add, mul and two bad codes
    '{OP_POP,   '0,        1, 1'b1, ST_POP_EMPTY, '0,        1'b1},
    '{OP_ADD,   '0,        1, 1'b1, ST_FEW,       '0,        1'b1},
    '{OP_MUL,   '0,        1, 1'b1, ST_FEW,       '0,        1'b1},
    '{OP_BAD,   '0,        1, 1'b1, ST_FEW,       '0,        1'b1},
    '{OP_RSVD7, Q_MAX,     1, 1'b1, ST_FEW,       '0,        1'b1},
    // single entry: arithmetic refused, bad codes flagged invalid
    '{OP_PUSH,  Q_MAX,     1, 1'b1, ST_OK,        Q_MAX,     1'b0},
    '{OP_ADD,   '0,        1, 1'b1, ST_FEW,       Q_MAX,     1'b0},
    '{OP_MUL,   '0,        1, 1'b1, ST_FEW,       Q_MAX,     1'b0},
    '{OP_BAD,   '0,        1, 1'b1, ST_INVALID,   Q_MAX,     1'b0},
    '{OP_RSVD5, Q_MIN,     1, 1'b1, ST_INVALID,   Q_MAX,     1'b0},
    // add saturates high, then low
    '{OP_PUSH,  Q_MAX,     1, 1'b1, ST_OK,        Q_MAX,     1'b0},
    '{OP_ADD,   '0,        1, 1'b1, ST_OK,        Q_MAX,     1'b0},
    '{OP_PUSH,  Q_MIN,     1, 1'b1, ST_OK,        Q_MIN,     1'b0},
    '{OP_PUSH,  Q_MIN,     1, 1'b1, ST_OK,        Q_MIN,     1'b0},
    '{OP_ADD,   '0,        1, 1'b1, ST_OK,        Q_MIN,     1'b0},
    // multiply saturates low (max * min), then high (min * -1.0)
    '{OP_MUL,   '0,        1, 1'b1, ST_OK,        Q_MIN,     1'b0},
    '{OP_PUSH,  Q_NEG_ONE, 1, 1'b1, ST_OK,        Q_NEG_ONE, 1'b0},
    '{OP_MUL,   '0,        1, 1'b1, ST_OK,        Q_MAX,     1'b0},
    // -1 lsb times 1 lsb floors to -1 lsb
    '{OP_PUSH,  '1,        1, 1'b1, ST_OK,        '1,        1'b0},
    '{OP_PUSH,  32'h1,     1, 1'b1, ST_OK,        32'h1,     1'b0},
    '{OP_MUL,   '0,        1, 1'b1, ST_OK,        '1,        1'b0},
    // fill to the top, then one push too many
    '{OP_PUSH,  Q_ONE_5,  14, 1'b0, ST_OK,        '0,        1'b0},
    '{OP_PUSH,  32'h1234_5678, 1, 1'b1, ST_FULL,  Q_ONE_5,   1'b0},
    '{OP_MUL,   '0,        1, 1'b0, ST_OK,        '0,        1'b0},
    '{OP_ADD,   Q_ONE,     1, 1'b0, ST_OK,        '0,        1'b0},
    // drain to empty and pop once more
    '{OP_POP,   '0,       14, 1'b0, ST_OK,        '0,        1'b0},
    '{OP_POP,   '0,        1, 1'b1, ST_POP_EMPTY, '0,        1'b1}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    calc_result_t want;
    logic [2:0]   op;
    logic [31:0]  val;
    int           mode;
    int           mode_left;
    int           idle_pct;
    int           roll;
    // op mix per mode: cut points for push, pop, add, mul; the rest are bad codes.
    // Mode 0 fills the stack, mode 1 drains it, mode 2 hovers in between.
    int           cuts [3][4];
    cuts = '{'{65, 75, 85, 95}, '{15, 55, 75, 95}, '{40, 60, 75, 90}};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        issue_request(directed_rows[i].op, directed_rows[i].val, want);
        if (directed_rows[i].typed) begin
          want.st    = directed_rows[i].st;
          want.top   = directed_rows[i].top;
          want.empty = directed_rows[i].empty;
        end
        awaited_results.push_back(want);
      end
    end
    wait_for_drain();

    // Three phases: sender idles 28%, then 52%, then never.
    // Each phase ends by letting every outstanding beat come home.
    mode      = 0;
    mode_left = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 52 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (mode_left == 0) begin
          mode      = $urandom_range(2);
          mode_left = $urandom_range(10, 40);
        end
        mode_left--;

        roll = $urandom_range(99);
        if (roll < cuts[mode][0])      op = OP_PUSH;
        else if (roll < cuts[mode][1]) op = OP_POP;
        else if (roll < cuts[mode][2]) op = OP_ADD;
        else if (roll < cuts[mode][3]) op = OP_MUL;
        else if ($urandom_range(3) == 0) op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        else op = OP_BAD;

        // Half are moderate magnitudes so products mostly stay in range; the rest are extremes
        // and raw 32-bit patterns to hit saturation and every bit.
        case ($urandom_range(5))
          0: case ($urandom_range(5))
               0: val = Q_MAX;
               1: val = Q_MIN;
               2: val = '0;
               3: val = '1;
               4: val = Q_ONE;
               default: val = Q_NEG_ONE;
             endcase
          1, 2: val = 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
          3:    val = 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
          default: val = $urandom;
        endcase

        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end

        issue_request(op, val, want);
        awaited_results.push_back(want);
      end
      wait_for_drain();
    end

    // wait on to catch any stray done beat
    repeat (6) @(posedge clk);

    $display("summary: %0d requests, %0d beats checked, %0d mismatches, deepest stack %0d",
             requests_issued, results_checked, mismatches, deepest);
    $display("summary: ok %0d, few operands %0d, invalid %0d, pop on empty %0d, full %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checker: every done beat pairs with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    calc_result_t want;
    if (!rst && done) begin
      if (status <= ST_FULL) status_tally[status]++;
      if (awaited_results.size() == 0) begin
        $display("%0t: done beat with nothing expected (status %0d, top %h, empty %b)",
                 $time, status, top_value, is_empty);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (status !== want.st) begin
          $display("%0t: status expected %0d, got %0d", $time, want.st, status);
          mismatches++;
        end
        if (top_value !== want.top) begin
          $display("%0t: top_value expected %h, got %h", $time, want.top, top_value);
          mismatches++;
        end
        if (is_empty !== want.empty) begin
          $display("%0t: is_empty expected %b, got %b", $time, want.empty, is_empty);
          mismatches++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, awaited_results.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rpnes_pkg.sv
hdl/rpnes_cell.sv
hdl/rpnes_alu.sv
hdl/rpn_evaluation_stack.sv
bench/testbench.sv
